@@ src/awv_pkg.sv @@
// ----------------------------------------------------------------------------
// awv_pkg
// Types, codes and constants shared by the files of the ADSR wavetable voice.
// ----------------------------------------------------------------------------
package awv_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM_SELECT  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE_GAIN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_SAMPLES   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DECAY_SAMPLES    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SUSTAIN_LEVEL    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_END_SAMPLES = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_SAMPLES  = 3'd7;
    localparam int CFG_DATA_W = 32;

    // Waveform codes
    localparam logic [2:0] WAVE_SINE         = 3'd0;
    localparam logic [2:0] WAVE_HALF_SINE    = 3'd1;
    localparam logic [2:0] WAVE_QUARTER_SINE = 3'd2;
    localparam logic [2:0] WAVE_RECT_SINE    = 3'd3;
    localparam logic [2:0] WAVE_SAWTOOTH     = 3'd4;
    localparam logic [2:0] WAVE_SQUARE       = 3'd5;
    localparam logic [2:0] WAVE_SILENT       = 3'd6;

    // Taylor coefficients of sin(pi/2 * x), Q30
    localparam logic [63:0] SIN_C1 = 64'd1686629713;
    localparam logic [63:0] SIN_C3 = 64'd693598668;
    localparam logic [63:0] SIN_C5 = 64'd85569306;
    localparam logic [63:0] SIN_C7 = 64'd5026991;
    localparam logic [63:0] SIN_C9 = 64'd172272;

    // Envelope in Q1.24, bounded by 1.0, so 25 bits suffice
    localparam int ENV_W = 25;
    localparam logic [ENV_W-1:0] ENV_ONE = 25'h100_0000;
    localparam int COUNT_W = 25;

    // Shared divider
    localparam int DIV_W     = 25;
    localparam int DIVISOR_W = 24;
    localparam int DIV_CNT_W = 5;

    // State memory map
    localparam int MEM_DEPTH  = 6;
    localparam int MEM_ADDR_W = 3;
    localparam int MEM_DATA_W = 32;
    localparam logic [MEM_ADDR_W-1:0] ADDR_PHASE   = 3'd0;
    localparam logic [MEM_ADDR_W-1:0] ADDR_COUNT   = 3'd1;
    localparam logic [MEM_ADDR_W-1:0] ADDR_ENV     = 3'd2;
    localparam logic [MEM_ADDR_W-1:0] ADDR_ATTACK  = 3'd3;
    localparam logic [MEM_ADDR_W-1:0] ADDR_DECAY   = 3'd4;
    localparam logic [MEM_ADDR_W-1:0] ADDR_RELEASE = 3'd5;

    typedef struct packed {
        logic note_start;
        logic phase_clear;
    } tick_in_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [15:0]        envelope_level;
        logic               note_last;
    } tick_out_t;

    typedef struct packed {
        logic                  wr_en;
        logic [MEM_ADDR_W-1:0] wr_addr;
        logic [MEM_DATA_W-1:0] wr_data;
        logic [MEM_ADDR_W-1:0] rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_RD_PHASE,
        ST_RD_COUNT,
        ST_RD_ENV,
        ST_RD_STEP,
        ST_ENV,
        ST_MUL,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        SEG_ATTACK,
        SEG_DECAY,
        SEG_HOLD,
        SEG_RELEASE
    } env_seg_t;

endpackage

@@ src/awv_div.sv @@
// ----------------------------------------------------------------------------
// awv_div
// Restoring divider, one quotient bit per cycle, shared by the three
// envelope step divisions.
// ----------------------------------------------------------------------------
module awv_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  awv_pkg::div_req_t           req,
    output logic                        done,
    output logic [awv_pkg::DIV_W-1:0]   quotient
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [awv_pkg::DIV_CNT_W-1:0]    count_reg;
    logic [awv_pkg::DIVISOR_W-1:0]    rem_reg;
    logic [awv_pkg::DIVISOR_W-1:0]    divisor_reg;
    logic [awv_pkg::DIV_W-1:0]        quo_reg;

    logic [awv_pkg::DIVISOR_W:0]      rem_try;
    logic [awv_pkg::DIVISOR_W:0]      rem_diff;
    logic                             fits;

    assign rem_try  = {rem_reg, quo_reg[awv_pkg::DIV_W-1]};
    assign rem_diff = rem_try - {1'b0, divisor_reg};
    assign fits     = (rem_try >= {1'b0, divisor_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == awv_pkg::DIV_CNT_W'(awv_pkg::DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
            quo_reg     <= req.dividend;
        end
        else if (busy_reg)
        begin
            // A remainder that does not fit stays below the divisor.
            rem_reg <= fits ? rem_diff[awv_pkg::DIVISOR_W-1:0]
                            : rem_try[awv_pkg::DIVISOR_W-1:0];
            quo_reg <= {quo_reg[awv_pkg::DIV_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ src/awv_state_mem.sv @@
// ----------------------------------------------------------------------------
// awv_state_mem
// Voice state memory: one write port, one read port with registered data.
// Entries read as zero until first written after reset.
// ----------------------------------------------------------------------------
module awv_state_mem (
    input  logic                             clk,
    input  logic                             rst_n,
    input  awv_pkg::mem_req_t                req,
    output logic [awv_pkg::MEM_DATA_W-1:0]   rd_data
);

    logic [awv_pkg::MEM_DATA_W-1:0] mem [awv_pkg::MEM_DEPTH];
    logic [awv_pkg::MEM_DEPTH-1:0]  valid_reg;
    logic [awv_pkg::MEM_DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_en)
        begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= valid_reg[req.rd_addr] ? mem[req.rd_addr] : '0;
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/awv_wave.sv @@
// ----------------------------------------------------------------------------
// awv_wave
// Waveform generator: quarter-wave sine table with registered read and the
// shaping of the selected waveform into magnitude and sign.
// ----------------------------------------------------------------------------
module awv_wave #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic        clk,
    input  logic [31:0] phase,
    input  logic [2:0]  wave_sel,
    output logic [15:0] wave_mag,
    output logic        wave_neg
);

    localparam int IDX_W     = $clog2(SINE_TABLE_DEPTH);
    localparam int PROD_W    = 30 + $clog2(SINE_TABLE_DEPTH + 1);
    localparam int TWO_DEPTH = 2 * SINE_TABLE_DEPTH;

    typedef logic [14:0] quarter_table_t [SINE_TABLE_DEPTH];

    // Entry k is 32767*sin(pi/2*x) at the centre of bin k, from the Horner
    // form of the Taylor series in Q30, rounded half up and capped.
    function automatic quarter_table_t build_table();
        quarter_table_t tbl;
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] v;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            x = (64'(2 * k + 1) << 30) / TWO_DEPTH;
            t = (x * x) >> 30;
            p = awv_pkg::SIN_C9;
            p = awv_pkg::SIN_C7 - ((p * t) >> 30);
            p = awv_pkg::SIN_C5 - ((p * t) >> 30);
            p = awv_pkg::SIN_C3 - ((p * t) >> 30);
            p = awv_pkg::SIN_C1 - ((p * t) >> 30);
            s = (x * p) >> 30;
            v = (s * 64'd32767 + 64'h2000_0000) >> 30;
            if (v > 64'd32767)
            begin
                v = 64'd32767;
            end
            tbl[k] = v[14:0];
        end
        return tbl;
    endfunction

    localparam quarter_table_t QUARTER_WAVE = build_table();

    logic [PROD_W-1:0] idx_prod;
    logic [IDX_W-1:0]  idx_raw;
    logic [IDX_W-1:0]  idx_sel;
    logic [14:0]       entry_reg;

    assign idx_prod = PROD_W'(phase[29:0]) * PROD_W'(SINE_TABLE_DEPTH);
    assign idx_raw  = idx_prod[30 +: IDX_W];
    // The table runs backward in the second and fourth quarters.
    assign idx_sel  = phase[30] ? (IDX_W'(SINE_TABLE_DEPTH - 1) - idx_raw) : idx_raw;

    always_ff @(posedge clk)
    begin
        entry_reg <= QUARTER_WAVE[idx_sel];
    end

    always_comb
    begin
        wave_mag = '0;
        wave_neg = 1'b0;
        unique case (wave_sel)
            awv_pkg::WAVE_SINE:
            begin
                wave_mag = {1'b0, entry_reg};
                wave_neg = phase[31];
            end
            awv_pkg::WAVE_HALF_SINE:
            begin
                wave_mag = phase[31] ? 16'd0 : {1'b0, entry_reg};
            end
            awv_pkg::WAVE_QUARTER_SINE:
            begin
                wave_mag = (phase[31:30] == 2'b00) ? {1'b0, entry_reg} : 16'd0;
            end
            awv_pkg::WAVE_RECT_SINE:
            begin
                wave_mag = {1'b0, entry_reg};
            end
            awv_pkg::WAVE_SAWTOOTH:
            begin
                wave_mag = phase[31] ? {1'b0, phase[30:16]}
                                     : (16'h8000 - {1'b0, phase[30:16]});
                wave_neg = ~phase[31];
            end
            awv_pkg::WAVE_SQUARE:
            begin
                wave_mag = 16'd32767;
                wave_neg = phase[31];
            end
            default:
            begin
                wave_mag = '0;
                wave_neg = 1'b0;
            end
        endcase
    end

endmodule

@@ src/adsr_wavetable_voice_unit.sv @@
// ----------------------------------------------------------------------------
// adsr_wavetable_voice_unit
// One synthesizer voice with a linear attack, decay, hold and release
// envelope over a selectable wavetable oscillator.
//
// Each input transaction is one sample tick and produces exactly one output
// transaction carrying the sample, the envelope level and a flag on the last
// sample of the note. The phase accumulator, sample counter, envelope and
// the three latched envelope steps live in a small state memory with a
// registered read port; a sequencer reads them one word per cycle, updates
// them and writes them back before it takes the next tick, so accesses never
// overlap. An ordinary tick runs through four state reads, the envelope
// update together with the first multiplier stage, the second multiplier
// stage, the result stage and the idle state in which the next tick is
// taken; the voice is ready again as soon as the result is loaded into the
// output register, even while that result still waits downstream. A tick
// that starts a note also runs the three step divisions on one shared
// bit-serial divider; each division starts the divider, shifts in the
// quotient bits and stores the quotient, and a division by zero is skipped
// and stores a zero step.
// Configuration is written through a plain write port and should be changed
// only while the voice is idle.
// ----------------------------------------------------------------------------
module adsr_wavetable_voice_unit #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [awv_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [awv_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  awv_pkg::tick_in_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output awv_pkg::tick_out_t                  out_data
);

    // Configuration registers
    logic [2:0]  waveform_select_reg;
    logic [31:0] phase_step_reg;
    logic [15:0] amplitude_gain_reg;
    logic [23:0] attack_samples_reg;
    logic [23:0] decay_samples_reg;
    logic [15:0] sustain_level_reg;
    logic [23:0] hold_end_samples_reg;
    logic [23:0] release_samples_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_select_reg  <= 3'd0;
            phase_step_reg       <= 32'd5365971;
            amplitude_gain_reg   <= 16'd32768;
            attack_samples_reg   <= 24'd0;
            decay_samples_reg    <= 24'd0;
            sustain_level_reg    <= 16'd65535;
            hold_end_samples_reg <= 24'd0;
            release_samples_reg  <= 24'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                awv_pkg::REG_WAVEFORM_SELECT:  waveform_select_reg  <= cfg_data[2:0];
                awv_pkg::REG_PHASE_STEP:       phase_step_reg       <= cfg_data[31:0];
                awv_pkg::REG_AMPLITUDE_GAIN:   amplitude_gain_reg   <= cfg_data[15:0];
                awv_pkg::REG_ATTACK_SAMPLES:   attack_samples_reg   <= cfg_data[23:0];
                awv_pkg::REG_DECAY_SAMPLES:    decay_samples_reg    <= cfg_data[23:0];
                awv_pkg::REG_SUSTAIN_LEVEL:    sustain_level_reg    <= cfg_data[15:0];
                awv_pkg::REG_HOLD_END_SAMPLES: hold_end_samples_reg <= cfg_data[23:0];
                awv_pkg::REG_RELEASE_SAMPLES:  release_samples_reg  <= cfg_data[23:0];
            endcase
        end
    end

    // Derived configuration values. The note length and the ramp bounds are
    // read live, so a note that is shortened under way ends on the next tick.
    logic [23:0]                   sustain_env;
    logic [awv_pkg::COUNT_W-1:0]   note_len;
    logic [awv_pkg::COUNT_W-1:0]   attack_decay_end;

    assign sustain_env      = {sustain_level_reg, 8'h00};
    assign note_len         = awv_pkg::COUNT_W'(hold_end_samples_reg)
                            + awv_pkg::COUNT_W'(release_samples_reg);
    assign attack_decay_end = awv_pkg::COUNT_W'(attack_samples_reg)
                            + awv_pkg::COUNT_W'(decay_samples_reg);

    // Sequencer state and per-tick working registers
    awv_pkg::state_t               state_reg;
    awv_pkg::state_t               state_next;
    logic [1:0]                    div_sel_reg;
    logic [1:0]                    div_sel_next;
    logic                          active_reg;
    logic                          active_next;
    logic                          note_start_reg;
    logic                          phase_clear_reg;
    logic [31:0]                   phase_reg;
    logic [awv_pkg::COUNT_W-1:0]   count_reg;
    logic [awv_pkg::ENV_W-1:0]     env_reg;
    logic                          neg_reg;
    logic [31:0]                   prod1_reg;
    logic [47:0]                   prod2_reg;
    logic                          out_valid_reg;
    awv_pkg::tick_out_t            out_data_reg;

    awv_pkg::mem_req_t             mem_req;
    logic [awv_pkg::MEM_DATA_W-1:0] mem_rd_data;
    awv_pkg::div_req_t             div_req;
    logic                          div_done;
    logic [awv_pkg::DIV_W-1:0]     div_quotient;
    logic [15:0]                   wave_mag;
    logic                          wave_neg;

    logic                          in_accept;
    logic                          slot_free;
    logic                          out_load;
    logic                          div_by_zero;
    logic [awv_pkg::MEM_ADDR_W-1:0] step_addr;
    awv_pkg::env_seg_t             env_seg;
    logic [awv_pkg::ENV_W-1:0]     step_val;
    logic [awv_pkg::ENV_W-1:0]     env_new;
    logic [15:0]                   level;
    logic                          last;
    logic [48:0]                   rounded;
    logic [17:0]                   mag_r;
    logic signed [15:0]            sample_val;

    awv_state_mem u_state_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    awv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quotient)
    );

    awv_wave #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_wave (
        .clk      (clk),
        .phase    (phase_reg),
        .wave_sel (waveform_select_reg),
        .wave_mag (wave_mag),
        .wave_neg (wave_neg)
    );

    assign in_accept = in_valid && (state_reg == awv_pkg::ST_IDLE);
    assign in_stall  = (state_reg != awv_pkg::ST_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == awv_pkg::ST_OUT) && slot_free;

    // Division operands for the step being computed: attack, decay, release.
    always_comb
    begin
        div_req.start = 1'b0;
        unique case (div_sel_reg)
            2'd0:
            begin
                div_req.dividend = awv_pkg::ENV_ONE;
                div_req.divisor  = attack_samples_reg;
                step_addr        = awv_pkg::ADDR_ATTACK;
            end
            2'd1:
            begin
                div_req.dividend = awv_pkg::ENV_ONE - awv_pkg::ENV_W'(sustain_env);
                div_req.divisor  = decay_samples_reg;
                step_addr        = awv_pkg::ADDR_DECAY;
            end
            default:
            begin
                div_req.dividend = awv_pkg::ENV_W'(sustain_env);
                div_req.divisor  = release_samples_reg;
                step_addr        = awv_pkg::ADDR_RELEASE;
            end
        endcase
        div_by_zero = (div_req.divisor == '0);
        if (state_reg == awv_pkg::ST_DIV_START && !div_by_zero)
        begin
            div_req.start = 1'b1;
        end
    end

    // Envelope segment of the current sample index, in priority order.
    always_comb
    begin
        priority if (count_reg < awv_pkg::COUNT_W'(attack_samples_reg))
        begin
            env_seg = awv_pkg::SEG_ATTACK;
        end
        else if (count_reg < attack_decay_end)
        begin
            env_seg = awv_pkg::SEG_DECAY;
        end
        else if (count_reg < awv_pkg::COUNT_W'(hold_end_samples_reg))
        begin
            env_seg = awv_pkg::SEG_HOLD;
        end
        else
        begin
            env_seg = awv_pkg::SEG_RELEASE;
        end
    end

    // Envelope update; the envelope never exceeds 1.0, so the headroom in
    // the attack is simply one minus the envelope.
    assign step_val = mem_rd_data[awv_pkg::ENV_W-1:0];

    always_comb
    begin
        unique case (env_seg)
            awv_pkg::SEG_ATTACK:
            begin
                env_new = (step_val >= (awv_pkg::ENV_ONE - env_reg))
                        ? awv_pkg::ENV_ONE : (env_reg + step_val);
            end
            awv_pkg::SEG_HOLD:
            begin
                env_new = awv_pkg::ENV_W'(sustain_env);
            end
            default:
            begin
                env_new = (step_val >= env_reg) ? '0 : (env_reg - step_val);
            end
        endcase
    end

    assign level = env_reg[24] ? 16'hFFFF : env_reg[23:8];
    assign last  = ({1'b0, count_reg} + 1'b1) >= {1'b0, note_len};

    // Product rounded half away from zero on the magnitude, then saturated.
    assign rounded = {1'b0, prod2_reg} + 49'h0_4000_0000;
    assign mag_r   = rounded[48:31];

    always_comb
    begin
        if (neg_reg)
        begin
            sample_val = (mag_r >= 18'd32768) ? 16'sh8000 : -$signed(mag_r[15:0]);
        end
        else
        begin
            sample_val = (mag_r >= 18'd32767) ? 16'sh7FFF : $signed(mag_r[15:0]);
        end
    end

    // Sequencer: next state, memory accesses and divider control.
    always_comb
    begin
        state_next      = state_reg;
        div_sel_next    = div_sel_reg;
        active_next     = active_reg;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = awv_pkg::ADDR_PHASE;
        mem_req.wr_data = '0;
        mem_req.rd_addr = awv_pkg::ADDR_PHASE;

        unique case (state_reg)
            awv_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    div_sel_next = 2'd0;
                    if (in_data.note_start)
                    begin
                        active_next = (note_len != '0);
                        state_next  = awv_pkg::ST_DIV_START;
                    end
                    else
                    begin
                        state_next = awv_pkg::ST_RD_PHASE;
                    end
                end
            end
            awv_pkg::ST_DIV_START:
            begin
                if (div_by_zero)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = step_addr;
                    mem_req.wr_data = '0;
                    div_sel_next    = div_sel_reg + 1'b1;
                    state_next      = (div_sel_reg == 2'd2) ? awv_pkg::ST_RD_PHASE
                                                            : awv_pkg::ST_DIV_START;
                end
                else
                begin
                    state_next = awv_pkg::ST_DIV_WAIT;
                end
            end
            awv_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = step_addr;
                    mem_req.wr_data = awv_pkg::MEM_DATA_W'(div_quotient);
                    div_sel_next    = div_sel_reg + 1'b1;
                    state_next      = (div_sel_reg == 2'd2) ? awv_pkg::ST_RD_PHASE
                                                            : awv_pkg::ST_DIV_START;
                end
            end
            awv_pkg::ST_RD_PHASE:
            begin
                mem_req.rd_addr = awv_pkg::ADDR_PHASE;
                state_next      = awv_pkg::ST_RD_COUNT;
            end
            awv_pkg::ST_RD_COUNT:
            begin
                mem_req.rd_addr = awv_pkg::ADDR_COUNT;
                state_next      = awv_pkg::ST_RD_ENV;
            end
            awv_pkg::ST_RD_ENV:
            begin
                mem_req.rd_addr = awv_pkg::ADDR_ENV;
                state_next      = awv_pkg::ST_RD_STEP;
            end
            awv_pkg::ST_RD_STEP:
            begin
                unique case (env_seg)
                    awv_pkg::SEG_DECAY:   mem_req.rd_addr = awv_pkg::ADDR_DECAY;
                    awv_pkg::SEG_RELEASE: mem_req.rd_addr = awv_pkg::ADDR_RELEASE;
                    default:              mem_req.rd_addr = awv_pkg::ADDR_ATTACK;
                endcase
                state_next = awv_pkg::ST_ENV;
            end
            awv_pkg::ST_ENV:
            begin
                mem_req.wr_en   = active_reg;
                mem_req.wr_addr = awv_pkg::ADDR_ENV;
                mem_req.wr_data = awv_pkg::MEM_DATA_W'(env_new);
                state_next      = awv_pkg::ST_MUL;
            end
            awv_pkg::ST_MUL:
            begin
                mem_req.wr_en   = active_reg;
                mem_req.wr_addr = awv_pkg::ADDR_COUNT;
                mem_req.wr_data = awv_pkg::MEM_DATA_W'(count_reg + 1'b1);
                state_next      = awv_pkg::ST_OUT;
            end
            awv_pkg::ST_OUT:
            begin
                // The phase advances only on active ticks, but a clear is
                // kept either way.
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = awv_pkg::ADDR_PHASE;
                mem_req.wr_data = phase_reg + (active_reg ? phase_step_reg : 32'd0);
                if (slot_free)
                begin
                    if (active_reg && last)
                    begin
                        active_next = 1'b0;
                    end
                    state_next = awv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = awv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= awv_pkg::ST_IDLE;
            div_sel_reg   <= 2'd0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            div_sel_reg <= div_sel_next;
            active_reg  <= active_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers. Count and envelope read as zero on the tick that
    // starts a note, since the restart is not written back separately.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            note_start_reg  <= in_data.note_start;
            phase_clear_reg <= in_data.phase_clear;
        end
        unique case (state_reg)
            awv_pkg::ST_RD_COUNT:
            begin
                phase_reg <= phase_clear_reg ? 32'd0 : mem_rd_data;
            end
            awv_pkg::ST_RD_ENV:
            begin
                count_reg <= note_start_reg ? '0 : mem_rd_data[awv_pkg::COUNT_W-1:0];
            end
            awv_pkg::ST_RD_STEP:
            begin
                env_reg <= note_start_reg ? '0 : mem_rd_data[awv_pkg::ENV_W-1:0];
            end
            awv_pkg::ST_ENV:
            begin
                env_reg   <= env_new;
                neg_reg   <= wave_neg;
                prod1_reg <= wave_mag * amplitude_gain_reg;
            end
            awv_pkg::ST_MUL:
            begin
                prod2_reg <= prod1_reg * level;
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            if (active_reg)
            begin
                out_data_reg.sample         <= sample_val;
                out_data_reg.envelope_level <= level;
                out_data_reg.note_last      <= last;
            end
            else
            begin
                out_data_reg <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // While the state words are being read back, nothing may be written:
    // this is what keeps a tick from seeing a half-updated state.
    a_no_write_during_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == awv_pkg::ST_RD_COUNT || state_reg == awv_pkg::ST_RD_ENV
         || state_reg == awv_pkg::ST_RD_STEP) |-> !mem_req.wr_en)
        else $error("state memory written during read-back");

    // The divider only reports a result while the sequencer waits for it.
    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == awv_pkg::ST_DIV_WAIT))
        else $error("divider result outside the wait state");

    // The final sample of a note leaves the voice idle.
    a_note_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && active_reg && last) |=> (!active_reg && out_data.note_last))
        else $error("note did not end on its last sample");

    // An idle tick delivers an all-zero result.
    a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !active_reg) |=> (out_data == '0 && out_valid))
        else $error("idle tick produced a non-zero result");

endmodule
